[src/q16_pkg.sv]
// Package: types, constants and opcode/status codes for the Q16.16 unit.
`default_nettype none
package q16_pkg;
   localparam int FRAC_BITS = 16;
   localparam int NUM_W     = 32 + FRAC_BITS;       // dividend magnitude width
   localparam int STAGES    = NUM_W;                // one quotient bit per cell

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_CVT  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DIV0 = 2'd1,
      ST_CVT  = 2'd2,
      ST_OP   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic [1:0]         status;
   } rsp_type;

   // Data handed from cell to cell.
   typedef struct packed {
      logic              vld;
      logic [NUM_W-1:0]  rem;    // partial remainder
      logic [NUM_W-1:0]  num;    // dividend bits, shifted out msb first
      logic [NUM_W-1:0]  quo;    // quotient bits so far
      logic [31:0]       dvs;    // divisor magnitude
      logic              neg;    // quotient negative
      logic              fixed;  // result already known, just carried
      logic [31:0]       res;
      logic [1:0]        st;
   } cell_type;
endpackage
`default_nettype wire

[src/q16_cell.sv]
// One cell of the chain: a restoring divide step plus carry of a finished item.
`default_nettype none
module q16_cell import q16_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cell_type c_in,
   output cell_type      c_out
);
   cell_type    c_ff, c_in_w;
   logic [NUM_W:0] trial;
   logic [NUM_W-1:0] sh;

   always_comb begin
      c_in_w     = c_in;
      c_in_w.vld = c_in.vld & ~reset;
      sh     = {c_in.rem[NUM_W-2:0], c_in.num[NUM_W-1]};
      trial  = {1'b0, sh} - {{(NUM_W-31){1'b0}}, c_in.dvs};
      if (!c_in.fixed) begin
         c_in_w.num = {c_in.num[NUM_W-2:0], 1'b0};
         if (!trial[NUM_W]) begin
            c_in_w.rem = trial[NUM_W-1:0];
            c_in_w.quo = {c_in.quo[NUM_W-2:0], 1'b1};
         end else begin
            c_in_w.rem = sh;
            c_in_w.quo = {c_in.quo[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in_w;
   end

   assign c_out = c_ff;
endmodule
`default_nettype wire

[src/q16_front.sv]
// Input stage: decode, multiply, float conversion and divide setup.
`default_nettype none
module q16_front import q16_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_type_type req_data,
   output cell_type          c_out
);
   cell_type           c_ff, c_in;
   logic signed [63:0] prod;
   logic [31:0]        mag_a, mag_b;
   logic               sgn;
   logic [7:0]         ex;
   logic [23:0]        m;
   logic [9:0]         sh;     // signed shift amount
   logic [55:0]        wide;
   logic [31:0]        cmag;
   logic               cbad;

   always_comb begin
      prod  = $signed(req_data.operand_a) * $signed(req_data.operand_b);
      mag_a = req_data.operand_a[31] ? 32'(-req_data.operand_a) : req_data.operand_a;
      mag_b = req_data.operand_b[31] ? 32'(-req_data.operand_b) : req_data.operand_b;

      sgn = req_data.operand_a[31];
      ex  = req_data.operand_a[30:23];
      m   = (ex == 8'd0) ? {1'b0, req_data.operand_a[22:0]}
                         : {1'b1, req_data.operand_a[22:0]};
      sh  = ((ex == 8'd0) ? 10'd1 : {2'b0, ex}) - 10'd150 + 10'(FRAC_BITS);
      cbad = 1'b0;
      wide = '0;
      if (!sh[9]) begin
         if (sh > 10'd31) cbad = 1'b1;
         else wide = {32'b0, m} << sh[4:0];
      end else if (10'(-sh) < 10'd24) begin
         wide = {32'b0, m} >> 5'(-sh);
      end
      if (m == 24'd0) cbad = 1'b0;
      if (wide[55:32] != 24'd0) cbad = 1'b1;
      cmag = wide[31:0];
      if (sgn ? (cmag > 32'h8000_0000) : cmag[31]) cbad = 1'b1;
      if (ex == 8'hFF) cbad = 1'b1;

      c_in       = '0;
      c_in.vld   = start & ~reset;
      c_in.fixed = 1'b1;
      unique case (op_type'(req_data.req_type))
         OP_MUL: begin
            c_in.res = prod[FRAC_BITS+31:FRAC_BITS];
            c_in.st  = ST_OK;
         end
         OP_DIV: begin
            if (req_data.operand_b == 32'sd0) begin
               c_in.st = ST_DIV0;
            end else begin
               c_in.fixed = 1'b0;
               c_in.st    = ST_OK;
               c_in.num   = {mag_a, {FRAC_BITS{1'b0}}};
               c_in.dvs   = mag_b;
               c_in.neg   = req_data.operand_a[31] ^ req_data.operand_b[31];
            end
         end
         OP_CVT: begin
            if (cbad) begin
               c_in.res = 32'h8000_0000;
               c_in.st  = ST_CVT;
            end else begin
               c_in.res = sgn ? 32'(-cmag) : cmag;
               c_in.st  = ST_OK;
            end
         end
         default: begin
            c_in.st = ST_OP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
   end

   assign c_out = c_ff;
endmodule
`default_nettype wire

[src/q16_fixed_point_unit.sv]
// Top level: Q16.16 multiply / divide / float-to-fixed unit.
// Every operation takes the same path from accepted start to rsp_valid:
// one decode stage, one cell per quotient bit, one output stage.
// Throughput: one item per cycle; busy is never raised, each cell holds one item.
// Synchronous active-high reset clears all valid flags; data registers are not reset.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
`default_nettype none
module q16_fixed_point_unit import q16_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_type_type req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);
   cell_type chain [0:STAGES];
   logic     valid_ff, valid_in;
   rsp_type  data_ff, data_in;
   logic [31:0] q;

   assign busy = 1'b0;

   q16_front u_front (
      .clock, .reset,
      .start   (start),
      .req_data(req_data),
      .c_out   (chain[0])
   );

   // The divide steps: each cell retires one quotient bit, msb first.
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      q16_cell u_cell (
         .clock, .reset,
         .c_in (chain[i]),
         .c_out(chain[i+1])
      );
   end

   // Final sign fix for division, low 32 bits kept.
   always_comb begin
      q        = chain[STAGES].quo[31:0];
      valid_in = chain[STAGES].vld;
      data_in.status = chain[STAGES].st;
      if (chain[STAGES].fixed) begin
         data_in.result = chain[STAGES].res;
      end else begin
         data_in.result = chain[STAGES].neg ? 32'(-q) : q;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule
`default_nettype wire

[bench/testbench.sv]
// Testbench for the Q16.16 multiply / divide / float-to-fixed unit.
`default_nettype none
module testbench;
   import q16_pkg::*;

   // Scoreboard: computes the expected response of each accepted request
   // and matches responses against the oldest pending one.
   class q16_scoreboard;
      rsp_type pending[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      // Signed multiply, arithmetic shift by FRAC_BITS, low 32 bits kept.
      static function logic [31:0] calc_mul(logic signed [31:0] a, logic signed [31:0] b);
         logic signed [63:0] prod;
         begin
            prod = 64'(a) * 64'(b);
            prod = prod >>> FRAC_BITS;
            return prod[31:0];
         end
      endfunction

      // Dividend scaled up in 64 bits, quotient truncated toward zero.
      static function logic [31:0] calc_div(logic signed [31:0] a, logic signed [31:0] b);
         logic signed [63:0] num;
         logic signed [63:0] q;
         begin
            num = 64'(a) <<< FRAC_BITS;
            q   = num / 64'(b);
            return q[31:0];
         end
      endfunction

      // Float bit pattern to fixed point; returns 0 when invalid.
      static function bit calc_cvt(logic [31:0] w, output logic [31:0] res);
         logic [7:0]  ex;
         logic [63:0] m;
         logic [63:0] mag;
         int          sh;
         begin
            ex = w[30:23];
            res = '0;
            if (ex == 8'hFF) return 0;
            if (ex == 0) begin
               m  = {41'd0, w[22:0]};
               sh = 1 - 150 + FRAC_BITS;
            end else begin
               m  = {40'd0, 1'b1, w[22:0]};
               sh = int'(ex) - 150 + FRAC_BITS;
            end
            if (m == 0) return 1;
            if (sh >= 0) begin
               if (sh > 31) return 0;
               mag = m << sh;
            end else begin
               mag = (-sh > 63) ? 64'd0 : (m >> (-sh));
            end
            if (w[31]) begin
               if (mag > 64'h8000_0000) return 0;
               res = 32'(64'd0 - mag);
            end else begin
               if (mag > 64'h7FFF_FFFF) return 0;
               res = mag[31:0];
            end
            return 1;
         end
      endfunction

      function void note_request(req_type_type rq);
         rsp_type     e;
         logic [31:0] r;
         begin
            e.result = '0;
            e.status = ST_OK;
            case (op_type'(rq.req_type))
               OP_MUL: e.result = calc_mul(rq.operand_a, rq.operand_b);
               OP_DIV: begin
                  if (rq.operand_b == 0) e.status = ST_DIV0;
                  else e.result = calc_div(rq.operand_a, rq.operand_b);
               end
               OP_CVT: begin
                  if (calc_cvt(rq.operand_a, r)) e.result = r;
                  else begin
                     e.result = 32'h8000_0000;
                     e.status = ST_CVT;
                  end
               end
               default: e.status = ST_OP;
            endcase
            pending.push_back(e);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         begin
            if (pending.size() == 0) begin
               $error("unexpected response result=%h status=%0d", got.result, got.status);
               errors++;
            end else begin
               e = pending.pop_front();
               if (got.result !== e.result) begin
                  $error("result: expected %h, actual %h", e.result, got.result);
                  errors++;
               end
               if (got.status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, got.status);
                  errors++;
               end
            end
         end
      endfunction
   endclass

   localparam int LATENCY   = FRAC_BITS + 34;
   localparam int WDOG_MAX  = 20 * LATENCY + 200;
   localparam int N_RANDOM  = 950;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_type_type req_data;
   logic         rsp_valid;
   rsp_type      rsp_data;

   q16_scoreboard sb;
   req_type_type  directed_q[$];
   int            idle_cycles;

   q16_fixed_point_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Responses are strobes; sampled at the edge that ends the strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   // Watchdog: cycles with neither a request nor a response accepted.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Random operand with bias toward edge values.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'h0001_0000;
         4: return 32'hFFFF_0000;
         5: return 32'($signed(16'($urandom)));
         default: return $urandom;
      endcase
   endfunction

   // Float patterns spread across exponents, including specials.
   function automatic logic [31:0] pick_float();
      logic [31:0] w;
      begin
         w = $urandom;
         case ($urandom_range(0, 5))
            0: w[30:23] = 8'(127 + $urandom_range(0, 20) - 8);   // near unity
            1: w[30:23] = 8'($urandom_range(136, 160));         // near range limit
            2: w[30:23] = 8'($urandom_range(100, 127));         // fractions
            3: w[30:23] = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
            default: ;
         endcase
         return w;
      end
   endfunction

   function automatic req_type_type make_random();
      req_type_type rq;
      begin
         rq.req_type  = 2'($urandom_range(0, 3));
         rq.operand_a = (rq.req_type == OP_CVT) ? pick_float() : pick_operand();
         rq.operand_b = pick_operand();
         // keep zero divisors from dominating while still hitting them
         if (rq.req_type == OP_DIV && rq.operand_b == 0 && $urandom_range(0, 3) != 0)
            rq.operand_b = $urandom | 32'h1;
         return rq;
      end
   endfunction

   // Drive one request: optional idle gap, then hold start until accepted.
   task automatic send_request(req_type_type rq, bit allow_gap);
      int gap;
      begin
         gap = allow_gap ? $urandom_range(0, 16) : 0;
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         start    <= 1'b1;
         req_data <= rq;
         do @(posedge clock); while (busy);
         sb.note_request(rq);
      end
   endtask

   task automatic add_directed(op_type op, logic [31:0] a, logic [31:0] b);
      req_type_type rq;
      begin
         rq.req_type  = op;
         rq.operand_a = a;
         rq.operand_b = b;
         directed_q.push_back(rq);
      end
   endtask

   initial begin
      req_type_type rq;
      bit           bursty;
      int           n;
      sb = new();

      // Multiply: unity, extremes, overflow wrap, negative rounding.
      add_directed(OP_MUL, 32'h0001_0000, 32'h0001_0000);
      add_directed(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_directed(OP_MUL, 32'h8000_0000, 32'h8000_0000);
      add_directed(OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
      add_directed(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
      // Divide: normal, zero divisor, overflow, min by -1.
      add_directed(OP_DIV, 32'h0003_0000, 32'h0002_0000);
      add_directed(OP_DIV, 32'h1234_5678, 32'h0000_0000);
      add_directed(OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
      add_directed(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      add_directed(OP_DIV, 32'hFFFF_FFFD, 32'h0002_0000);
      // Conversion: zero, -0, denormal, 1.0, -1.5, NaN, infinity,
      // exactly -2^15 (in range), 2^15 (out of range), tiny value.
      add_directed(OP_CVT, 32'h0000_0000, 32'h0);
      add_directed(OP_CVT, 32'h8000_0000, 32'h0);
      add_directed(OP_CVT, 32'h0000_0001, 32'h0);
      add_directed(OP_CVT, 32'h3F80_0000, 32'h0);
      add_directed(OP_CVT, 32'hBFC0_0000, 32'h0);
      add_directed(OP_CVT, 32'h7FC0_0000, 32'h0);
      add_directed(OP_CVT, 32'hFF80_0000, 32'h0);
      add_directed(OP_CVT, 32'hC700_0000, 32'h0);
      add_directed(OP_CVT, 32'h4700_0000, 32'h0);
      add_directed(OP_CVT, 32'h3700_0000, 32'h0);
      add_directed(OP_CVT, 32'h46FF_FFFF, 32'h0);
      // Unknown operation.
      add_directed(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i]) send_request(directed_q[i], 1'b0);

      // Random part in bursts: some back-to-back, some with random gaps.
      n = 0;
      while (n < N_RANDOM) begin
         bursty = $urandom_range(0, 2) == 0;
         repeat ($urandom_range(5, 40)) begin
            if (n < N_RANDOM) begin
               rq = make_random();
               send_request(rq, !bursty);
               n++;
            end
         end
      end
      start <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
src/q16_pkg.sv
src/q16_cell.sv
src/q16_front.sv
src/q16_fixed_point_unit.sv
bench/testbench.sv
